// ===== src/rti_pkg.sv =====
// rti_pkg: shared types, widths and register indexes for the ray/triangle
// intersection pipeline. No dependencies.
`default_nettype none
package rti_pkg;
  localparam int CW = 24;            // coordinate width
  localparam int EW = 25;            // edge / difference width
  localparam int PW = 50;            // cross-product term width
  localparam int XW = 51;            // cross-product result width
  localparam int HW = 26;            // split half width for the dot multiplies
  localparam int DW = 80;            // dot-product / numerator width
  localparam int TW = 32;            // threshold / epsilon width
  localparam int MW = 78;            // determinant magnitude width
  localparam int CKW = 26;           // determinant chunk width for t * D
  localparam int NUM_STAGES = 9;

  localparam int IDXW = 4;
  localparam logic [IDXW-1:0] REG_ORG_X = 4'd0;
  localparam logic [IDXW-1:0] REG_ORG_Y = 4'd1;
  localparam logic [IDXW-1:0] REG_ORG_Z = 4'd2;
  localparam logic [IDXW-1:0] REG_DIR_X = 4'd3;
  localparam logic [IDXW-1:0] REG_DIR_Y = 4'd4;
  localparam logic [IDXW-1:0] REG_DIR_Z = 4'd5;
  localparam logic [IDXW-1:0] REG_DET_EPS = 4'd6;
  localparam logic [IDXW-1:0] REG_T_THR = 4'd7;

  localparam logic [TW-1:0] DET_EPS_RESET = 32'd28147498;
  localparam logic [TW-1:0] T_THR_RESET = 32'd429;

  typedef logic [CW-1:0] coord_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;
  typedef struct packed {
    vec_t v0;
    vec_t v1;
    vec_t v2;
  } trngl_t;
  typedef struct packed {
    vec_t         org;
    vec_t         dir;
    logic [TW-1:0] eps;
    logic [TW-1:0] tthr;
  } ray_cfg_t;
endpackage
`default_nettype wire

// ===== src/rti_pipe.sv =====
// rti_pipe: nine-stage Moller-Trumbore datapath, advanced by a shared enable.
// Depends on rti_pkg.
`default_nettype none
module rti_pipe (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire rti_pkg::trngl_t   tri_i,
  input  wire rti_pkg::ray_cfg_t cfg_i,
  output logic                   hit_o
);
  localparam int EW = rti_pkg::EW;
  localparam int PW = rti_pkg::PW;
  localparam int XW = rti_pkg::XW;
  localparam int HW = rti_pkg::HW;
  localparam int DW = rti_pkg::DW;
  localparam int TW = rti_pkg::TW;
  localparam int MW = rti_pkg::MW;
  localparam int CKW = rti_pkg::CKW;
  localparam int RW = TW + 3 * CKW;  // t * D width

  logic [23:0] va0 [3];
  logic [23:0] va1 [3];
  logic [23:0] va2 [3];
  logic [23:0] org [3];
  logic [23:0] dir [3];
  logic signed [EW-1:0] dir25 [3];

  assign va0[0] = tri_i.v0.x; assign va0[1] = tri_i.v0.y; assign va0[2] = tri_i.v0.z;
  assign va1[0] = tri_i.v1.x; assign va1[1] = tri_i.v1.y; assign va1[2] = tri_i.v1.z;
  assign va2[0] = tri_i.v2.x; assign va2[1] = tri_i.v2.y; assign va2[2] = tri_i.v2.z;
  assign org[0] = cfg_i.org.x; assign org[1] = cfg_i.org.y; assign org[2] = cfg_i.org.z;
  assign dir[0] = cfg_i.dir.x; assign dir[1] = cfg_i.dir.y; assign dir[2] = cfg_i.dir.z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir25[i] = $signed({dir[i][23], dir[i]});
    end
  end

  // stage 1: edges and origin offset
  logic signed [EW-1:0] e1_1_r [3];
  logic signed [EW-1:0] e2_1_r [3];
  logic signed [EW-1:0] s_1_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_1_r[i] <= $signed({va1[i][23], va1[i]}) - $signed({va0[i][23], va0[i]});
        e2_1_r[i] <= $signed({va2[i][23], va2[i]}) - $signed({va0[i][23], va0[i]});
        s_1_r[i]  <= $signed({org[i][23], org[i]}) - $signed({va0[i][23], va0[i]});
      end
    end
  end

  // stage 2: cross-product terms, h = dir x e2, q = s x e1
  logic signed [PW-1:0] hpa_r [3];
  logic signed [PW-1:0] hpb_r [3];
  logic signed [PW-1:0] qpa_r [3];
  logic signed [PW-1:0] qpb_r [3];
  logic signed [EW-1:0] e1_2_r [3];
  logic signed [EW-1:0] e2_2_r [3];
  logic signed [EW-1:0] s_2_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        hpa_r[i] <= dir25[(i + 1) % 3] * e2_1_r[(i + 2) % 3];
        hpb_r[i] <= dir25[(i + 2) % 3] * e2_1_r[(i + 1) % 3];
        qpa_r[i] <= s_1_r[(i + 1) % 3] * e1_1_r[(i + 2) % 3];
        qpb_r[i] <= s_1_r[(i + 2) % 3] * e1_1_r[(i + 1) % 3];
        e1_2_r[i] <= e1_1_r[i];
        e2_2_r[i] <= e2_1_r[i];
        s_2_r[i]  <= s_1_r[i];
      end
    end
  end

  // stage 3: cross products
  logic signed [XW-1:0] h_r [3];
  logic signed [XW-1:0] q_r [3];
  logic signed [EW-1:0] e1_3_r [3];
  logic signed [EW-1:0] e2_3_r [3];
  logic signed [EW-1:0] s_3_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        h_r[i] <= $signed({hpa_r[i][PW-1], hpa_r[i]}) - $signed({hpb_r[i][PW-1], hpb_r[i]});
        q_r[i] <= $signed({qpa_r[i][PW-1], qpa_r[i]}) - $signed({qpb_r[i][PW-1], qpb_r[i]});
        e1_3_r[i] <= e1_2_r[i];
        e2_3_r[i] <= e2_2_r[i];
        s_3_r[i]  <= s_2_r[i];
      end
    end
  end

  // stage 4: dot-product partials; wide operand split into signed high and
  // unsigned low halves. Dots: 0 det, 1 nu, 2 nv, 3 nt.
  logic signed [EW-1:0] opa [4][3];
  logic signed [XW-1:0] opb [4][3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      opa[0][i] = e1_3_r[i]; opb[0][i] = h_r[i];
      opa[1][i] = s_3_r[i];  opb[1][i] = h_r[i];
      opa[2][i] = dir25[i];  opb[2][i] = q_r[i];
      opa[3][i] = e2_3_r[i]; opb[3][i] = q_r[i];
    end
  end

  logic signed [XW-1:0] ph_r [4][3];
  logic signed [XW-1:0] pl_r [4][3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 3; i++) begin
          ph_r[k][i] <= opa[k][i] * $signed(opb[k][i][XW-1:XW-HW]);
          pl_r[k][i] <= opa[k][i] * $signed({1'b0, opb[k][i][XW-HW-1:0]});
        end
      end
    end
  end

  // stage 5: recombine partials
  logic signed [DW-1:0] pr_r [4][3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 3; i++) begin
          pr_r[k][i] <= (DW'(ph_r[k][i]) <<< (XW - HW)) + DW'(pl_r[k][i]);
        end
      end
    end
  end

  // stage 6: dot sums
  logic signed [DW-1:0] dot_r [4];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        dot_r[k] <= pr_r[k][0] + pr_r[k][1] + pr_r[k][2];
      end
    end
  end

  // stage 7: fold the determinant sign into all numerators
  logic signed [DW-1:0] adj_r [4];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        adj_r[k] <= dot_r[0][DW-1] ? -dot_r[k] : dot_r[k];
      end
    end
  end

  // stage 8: range checks and t_threshold * D partials
  logic [MW-1:0]         dmag;
  logic signed [DW:0]    uv_sum;
  logic                  ok_nxt;
  assign dmag   = adj_r[0][MW-1:0];
  assign uv_sum = {adj_r[1][DW-1], adj_r[1]} + {adj_r[2][DW-1], adj_r[2]};
  assign ok_nxt = (adj_r[0] != '0)
               && (adj_r[0] >= $signed({{(DW-TW){1'b0}}, cfg_i.eps}))
               && !adj_r[1][DW-1] && (adj_r[1] <= adj_r[0])
               && !adj_r[2][DW-1]
               && (uv_sum <= $signed({adj_r[0][DW-1], adj_r[0]}));

  logic                  ok_r;
  logic [TW+CKW-1:0]     tp_r [3];
  logic signed [DW-1:0]  nt_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ok_r <= ok_nxt;
      nt_r <= adj_r[3];
      for (int j = 0; j < 3; j++) begin
        tp_r[j] <= cfg_i.tthr * dmag[j*CKW +: CKW];
      end
    end
  end

  // stage 9: t * D < nt * 2^32
  logic [RW-1:0]        rhs;
  logic [DW+TW-2:0]     lhs;
  assign rhs = RW'(tp_r[0]) + (RW'(tp_r[1]) << CKW) + (RW'(tp_r[2]) << (2 * CKW));
  assign lhs = {nt_r[DW-2:0], {TW{1'b0}}};

  logic hit_r;
  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= ok_r && !nt_r[DW-1] && ((DW+TW-1)'(rhs) < lhs);
    end
  end
  assign hit_o = hit_r;
endmodule
`default_nettype wire

// ===== src/ray_triangle_intersect.sv =====
// ray_triangle_intersect: one triangle test per beat; throughput one beat per
// cycle while the output beat is not stalled.
// The whole nine-stage pipeline advances together and holds while the output
// beat is stalled. Synchronous active-low reset clears valid bits and loads
// ray registers with zero, det_epsilon 28147498 and t_threshold 429.
// Depends on rti_pkg and rti_pipe.
`default_nettype none
module ray_triangle_intersect (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [23:0] in_vert0_x,
  input  wire logic [23:0] in_vert0_y,
  input  wire logic [23:0] in_vert0_z,
  input  wire logic [23:0] in_vert1_x,
  input  wire logic [23:0] in_vert1_y,
  input  wire logic [23:0] in_vert1_z,
  input  wire logic [23:0] in_vert2_x,
  input  wire logic [23:0] in_vert2_y,
  input  wire logic [23:0] in_vert2_z,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_hit,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_idx,
  input  wire logic [31:0] cfg_wdata
);
  localparam int NS = rti_pkg::NUM_STAGES;

  rti_pkg::ray_cfg_t cfg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.org  <= '0;
      cfg_r.dir  <= '0;
      cfg_r.eps  <= rti_pkg::DET_EPS_RESET;
      cfg_r.tthr <= rti_pkg::T_THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        rti_pkg::REG_ORG_X:   cfg_r.org.x <= cfg_wdata[23:0];
        rti_pkg::REG_ORG_Y:   cfg_r.org.y <= cfg_wdata[23:0];
        rti_pkg::REG_ORG_Z:   cfg_r.org.z <= cfg_wdata[23:0];
        rti_pkg::REG_DIR_X:   cfg_r.dir.x <= cfg_wdata[23:0];
        rti_pkg::REG_DIR_Y:   cfg_r.dir.y <= cfg_wdata[23:0];
        rti_pkg::REG_DIR_Z:   cfg_r.dir.z <= cfg_wdata[23:0];
        rti_pkg::REG_DET_EPS: cfg_r.eps   <= cfg_wdata;
        rti_pkg::REG_T_THR:   cfg_r.tthr  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [NS-1:0] vld_r;
  logic en;
  assign en       = !vld_r[NS-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  rti_pkg::trngl_t tri_in;
  assign tri_in.v0 = '{x: in_vert0_x, y: in_vert0_y, z: in_vert0_z};
  assign tri_in.v1 = '{x: in_vert1_x, y: in_vert1_y, z: in_vert1_z};
  assign tri_in.v2 = '{x: in_vert2_x, y: in_vert2_y, z: in_vert2_z};

  rti_pipe u_pipe (
    .clk   (clk),
    .en    (en),
    .tri_i (tri_in),
    .cfg_i (cfg_r),
    .hit_o (out_hit)
  );

  assign out_valid = vld_r[NS-1];

  // an empty last stage never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[NS-1] |-> in_ready)
    else $error("input blocked with empty output stage");

  // a stall freezes every valid bit
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("valid bits moved during stall");

  // an accepted beat lands in the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted beat lost at pipeline entry");
endmodule
`default_nettype wire

// ===== sim/tb_ray_triangle_intersect.sv =====
// Testbench for ray_triangle_intersect: streams triangles against several ray
// settings and checks each hit flag against an exact integer intersection test.
// Depends on rti_pkg and the ray_triangle_intersect RTL.
`timescale 1ns / 1ps
module tb_ray_triangle_intersect;

  typedef logic signed [127:0] wide_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  rti_pkg::trngl_t  tri_drv = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_hit;
  logic             cfg_we = 1'b0;
  logic [3:0]       cfg_idx = '0;
  logic [31:0]      cfg_wdata = '0;

  ray_triangle_intersect i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_vert0_x(tri_drv.v0.x), .in_vert0_y(tri_drv.v0.y), .in_vert0_z(tri_drv.v0.z),
    .in_vert1_x(tri_drv.v1.x), .in_vert1_y(tri_drv.v1.y), .in_vert1_z(tri_drv.v1.z),
    .in_vert2_x(tri_drv.v2.x), .in_vert2_y(tri_drv.v2.y), .in_vert2_z(tri_drv.v2.z),
    .out_valid(out_valid), .out_ready(out_ready), .out_hit(out_hit),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ray settings as the block should hold them
  rti_pkg::coord_t ray_org [3];
  rti_pkg::coord_t ray_dir [3];
  logic [31:0]     det_eps;
  logic [31:0]     t_min;

  rti_pkg::trngl_t tri_pending [$];
  bit     hit_expected [$];
  int     src_idle_pct = 0;
  int     snk_idle_pct = 0;
  int     mismatches = 0;

  function automatic wide_t sx(rti_pkg::coord_t c);
    return wide_t'($signed(c));
  endfunction

  function automatic bit tri_hits(rti_pkg::trngl_t t);
    wide_t p0 [3], e1 [3], e2 [3], s [3], d [3], h [3], q [3];
    wide_t det, nu, nv, nt;
    p0[0] = sx(t.v0.x); p0[1] = sx(t.v0.y); p0[2] = sx(t.v0.z);
    e1[0] = sx(t.v1.x) - p0[0]; e1[1] = sx(t.v1.y) - p0[1]; e1[2] = sx(t.v1.z) - p0[2];
    e2[0] = sx(t.v2.x) - p0[0]; e2[1] = sx(t.v2.y) - p0[1]; e2[2] = sx(t.v2.z) - p0[2];
    for (int i = 0; i < 3; i++) begin
      d[i] = sx(ray_dir[i]);
      s[i] = sx(ray_org[i]) - p0[i];
    end
    h[0] = d[1] * e2[2] - d[2] * e2[1];
    h[1] = d[2] * e2[0] - d[0] * e2[2];
    h[2] = d[0] * e2[1] - d[1] * e2[0];
    q[0] = s[1] * e1[2] - s[2] * e1[1];
    q[1] = s[2] * e1[0] - s[0] * e1[2];
    q[2] = s[0] * e1[1] - s[1] * e1[0];
    det = e1[0] * h[0] + e1[1] * h[1] + e1[2] * h[2];
    nu  = s[0] * h[0] + s[1] * h[1] + s[2] * h[2];
    nv  = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
    nt  = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
    if (det < 0) begin
      det = -det; nu = -nu; nv = -nv; nt = -nt;
    end
    if (det == 0 || det < wide_t'({96'b0, det_eps})) return 1'b0;
    if (nu < 0 || nu > det || nv < 0 || nu + nv > det) return 1'b0;
    return (nt <<< 32) > wide_t'({96'b0, t_min}) * det;
  endfunction

  // driver: next triangle goes out once the current beat is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (tri_pending.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        tri_drv <= tri_pending[0];
        hit_expected.push_back(tri_hits(tri_pending[0]));
        void'(tri_pending.pop_front());
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: result beats against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= snk_idle_pct);
      if (out_valid && out_ready) begin
        if (hit_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat, hit=%0b", out_hit);
        end else begin
          if (out_hit !== hit_expected[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("hit mismatch: expected %0b got %0b", hit_expected[0], out_hit);
          end
          void'(hit_expected.pop_front());
        end
      end
    end
  end

  task automatic reg_write(logic [3:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    case (idx) inside
      rti_pkg::REG_ORG_X, rti_pkg::REG_ORG_Y, rti_pkg::REG_ORG_Z:
        ray_org[idx - rti_pkg::REG_ORG_X] = data[23:0];
      rti_pkg::REG_DIR_X, rti_pkg::REG_DIR_Y, rti_pkg::REG_DIR_Z:
        ray_dir[idx - rti_pkg::REG_DIR_X] = data[23:0];
      rti_pkg::REG_DET_EPS: det_eps = data;
      rti_pkg::REG_T_THR:   t_min = data;
      default: ;
    endcase
  endtask

  task automatic set_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                         logic [31:0] eps, logic [31:0] tthr);
    // upper data bits are junk on purpose for the 24-bit registers
    reg_write(rti_pkg::REG_ORG_X, {8'($urandom_range(255)), 24'(ox)});
    reg_write(rti_pkg::REG_ORG_Y, {8'($urandom_range(255)), 24'(oy)});
    reg_write(rti_pkg::REG_ORG_Z, {8'($urandom_range(255)), 24'(oz)});
    reg_write(rti_pkg::REG_DIR_X, {8'($urandom_range(255)), 24'(dx)});
    reg_write(rti_pkg::REG_DIR_Y, {8'($urandom_range(255)), 24'(dy)});
    reg_write(rti_pkg::REG_DIR_Z, {8'($urandom_range(255)), 24'(dz)});
    reg_write(rti_pkg::REG_DET_EPS, eps);
    reg_write(rti_pkg::REG_T_THR, tthr);
    reg_write(4'($urandom_range(8, 15)), $urandom);  // unmapped index
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic rti_pkg::trngl_t mk_tri(int ax, int ay, int az, int bx, int by, int bz,
                                             int cx, int cy, int cz);
    rti_pkg::trngl_t t;
    t.v0 = '{24'(ax), 24'(ay), 24'(az)};
    t.v1 = '{24'(bx), 24'(by), 24'(bz)};
    t.v2 = '{24'(cx), 24'(cy), 24'(cz)};
    return t;
  endfunction

  function automatic rti_pkg::coord_t near(int c, int span);
    return rti_pkg::coord_t'(c + int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // triangle scattered around a point on the ray, or plain noise
  function automatic rti_pkg::trngl_t rand_tri();
    rti_pkg::trngl_t t;
    int pt [3];
    int span, kq;
    if ($urandom_range(9) == 0) begin
      t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 24'($urandom)};
    end else begin
      kq = ($urandom_range(9) == 0) ? -int'($urandom_range(1 << 18))
                                    : int'($urandom_range(8 << 16));
      for (int i = 0; i < 3; i++)
        pt[i] = int'(sx(ray_org[i])) + int'((longint'(sx(ray_dir[i])) * kq) >>> 16);
      span = 1 << $urandom_range(6, 19);
      t.v0 = '{near(pt[0], span), near(pt[1], span), near(pt[2], span)};
      t.v1 = '{near(pt[0], span), near(pt[1], span), near(pt[2], span)};
      t.v2 = '{near(pt[0], span), near(pt[1], span), near(pt[2], span)};
      if ($urandom_range(29) == 0) t.v2 = t.v1;  // degenerate
    end
    return t;
  endfunction

  task automatic run_batch(int n);
    for (int i = 0; i < n; i++) tri_pending.push_back(rand_tri());
    while (tri_pending.size() > 0 || in_valid || hit_expected.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    ray_org = '{default: '0};
    ray_dir = '{default: '0};
    det_eps = rti_pkg::DET_EPS_RESET;
    t_min = rti_pkg::T_THR_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    src_idle_pct = 33;
    snk_idle_pct = 49;

    // reset values: zero direction, every test a miss
    tri_pending.push_back(mk_tri(-65536, -65536, 0, 65536, -65536, 0, 0, 65536, 0));
    run_batch(10);

    set_ray(0, 0, -5 << 16, 0, 0, 1 << 16, rti_pkg::DET_EPS_RESET, rti_pkg::T_THR_RESET);
    tri_pending.push_back(mk_tri(-65536, -65536, 0, 65536, -65536, 0, 0, 65536, 0));
    tri_pending.push_back(mk_tri(-65536, -65536, -10 << 16, 65536, -65536, -10 << 16,
                                 0, 65536, -10 << 16));                      // behind
    tri_pending.push_back(mk_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0));        // on a vertex
    tri_pending.push_back(mk_tri(-65536, 0, 0, 65536, 0, 0, 0, 65536, 0));   // on an edge
    tri_pending.push_back(mk_tri(65536, 65536, 0, 131072, 65536, 0, 65536, 131072, 0));
    tri_pending.push_back(mk_tri(8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
                                 8388607, 8388607, 8388607));
    tri_pending.push_back(mk_tri(-8388608, -8388608, -8388608, -8388608, -8388608,
                                 -8388608, -8388608, -8388608, -8388608));
    tri_pending.push_back(mk_tri(-8388608, -8388608, 8388607, 8388607, -8388608, 8388607,
                                 0, 8388607, 8388607));
    tri_pending.push_back(mk_tri(8388607, -8388608, -8388608, -8388608, 8388607, 0,
                                 0, 0, 8388607));
    tri_pending.push_back(mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    tri_pending.push_back(mk_tri(0, 0, 0, 65536, 0, 0, 0, 0, 65536));       // parallel
    run_batch(140);

    set_ray(0, 0, 0, 1 << 16, 1 << 16, 1 << 16, 32'd0, 32'd0);
    tri_pending.push_back(mk_tri(65536, 65536, 65536, 65536, 65536, 65536,
                                 65536, 65536, 65536));  // zero det with zero band
    run_batch(150);

    src_idle_pct = 49;
    snk_idle_pct = 33;
    set_ray(8388607, -8388608, 8388607, -8388608, 8388607, -8388608,
            32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_batch(150);
    set_ray(int'($urandom_range(40 << 16)) - (20 << 16), int'($urandom_range(40 << 16)) - (20 << 16),
            int'($urandom_range(40 << 16)) - (20 << 16), int'($urandom_range(4 << 16)) - (2 << 16),
            int'($urandom_range(4 << 16)) - (2 << 16), 1 << 14, $urandom_range(1 << 20),
            $urandom);
    run_batch(150);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    set_ray(-8388608, 8388607, -8388608, 8388607, -8388608, 8388607, 32'd0, 32'hFFFF_FFFF);
    run_batch(75);
    set_ray(int'($urandom_range(40 << 16)) - (20 << 16), int'($urandom_range(40 << 16)) - (20 << 16),
            int'($urandom_range(40 << 16)) - (20 << 16), int'($urandom_range(4 << 16)) - (2 << 16),
            int'($urandom_range(4 << 16)) - (2 << 16), int'($urandom_range(4 << 16)) - (2 << 16),
            32'hFFFF_FFFF, 32'd0);
    run_batch(75);
    set_ray(3 << 16, -2 << 16, 1 << 16, -1 << 14, 1 << 16, 1 << 15, 32'd1, 32'd1 << 31);
    run_batch(150);

    if (mismatches == 0 && hit_expected.size() == 0) begin
      $display("[ray_triangle_intersect] OK");
    end else begin
      $display("[ray_triangle_intersect] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[ray_triangle_intersect] ERROR");
    $finish;
  end
endmodule
